FILE: src/aig_pkg.sv
// Shared types and constants for the Apollonian gasket point stepper.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package aig_pkg;

  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [2:0] {
    CFG_LEFT   = 3'd0,
    CFG_BOTTOM = 3'd1,
    CFG_VIEWH  = 3'd2,
    CFG_XSCALE = 3'd3,
    CFG_YSCALE = 3'd4,
    CFG_WIDTH  = 3'd5,
    CFG_HEIGHT = 3'd6,
    CFG_COLOUR = 3'd7
  } cfg_idx_t;

  // Datapath operations, one per controller step.
  typedef enum logic [4:0] {
    OP_U    = 5'd0,   // u = 1 + r - x
    OP_SQU  = 5'd1,   // acc = u^2
    OP_D    = 5'd2,   // d = sat(acc + y^2)
    OP_DIVA = 5'd3,   // start 3u / d
    OP_A0   = 5'd4,   // a0 = sat(q - shift)
    OP_DIVB = 5'd5,   // start 3y / d
    OP_B0   = 5'd6,   // b0 = q
    OP_SQA  = 5'd7,   // acc = a0^2
    OP_E    = 5'd8,   // e = sat(acc + b0^2)
    OP_DIVF = 5'd9,   // start a0 / e
    OP_FX   = 5'd10,  // f1x = q
    OP_DIVG = 5'd11,  // start -b0 / e
    OP_FY   = 5'd12,  // f1y = q
    OP_MX   = 5'd13,  // mx = f1x * r
    OP_MY   = 5'd14,  // my = f1y * r
    OP_PX   = 5'd15,  // pixel x product
    OP_PY   = 5'd16,  // pixel y product
    OP_FIN  = 5'd17,  // result and point update
    OP_NONE = 5'd18
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;      // capture branch at item acceptance
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_stat_t;

endpackage

FILE: src/aig_divider.sv
// Restoring fixed-point divider: (|num| << F) / den, one quotient bit per cycle.
// Depends on nothing but its own ports.
`timescale 1ns / 1ps
module aig_divider #(
  parameter int FRAC = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [35:0] num,
  input  logic        [31:0] den,
  output logic               busy,
  output logic signed [31:0] quo
);
  localparam int NW = 36 + FRAC;   // dividend width
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dvd_r, dvd_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt, zero_r, zero_nxt, nz_r, nz_nxt;
  logic          busy_r, busy_nxt;
  logic [32:0]   trial;
  logic [35:0]   mag;
  logic [NW-1:0] q;

  assign mag = num[35] ? 36'(-num) : 36'(num);
  assign trial = {rem_r[31:0], dvd_r[NW-1]} - {1'b0, den};

  always_comb begin
    dvd_nxt = dvd_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    neg_nxt = neg_r; zero_nxt = zero_r; nz_nxt = nz_r; busy_nxt = busy_r;
    if (start) begin
      dvd_nxt  = {mag, {FRAC{1'b0}}};
      rem_nxt  = '0;
      cnt_nxt  = CW'(NW);
      neg_nxt  = num[35];
      nz_nxt   = (num != 0);
      zero_nxt = (den == 0);
      busy_nxt = (den != 0);
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial;
        dvd_nxt = {dvd_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], dvd_r[NW-1]};
        dvd_nxt = {dvd_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= busy_nxt;
    dvd_r <= dvd_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt;
    neg_r <= neg_nxt; zero_r <= zero_nxt; nz_r <= nz_nxt;
  end

  assign q = dvd_r;
  always_comb begin
    if (zero_r) quo = !nz_r ? 32'sd0 : (neg_r ? 32'sh80000000 : 32'sh7fffffff);
    else if (neg_r) quo = (q > NW'(33'h80000000)) ? 32'sh80000000 : 32'(-q);
    else quo = (q > NW'(32'h7fffffff)) ? 32'sh7fffffff : 32'(q);
  end
  assign busy = busy_r;
endmodule

FILE: src/aig_datapath.sv
// Datapath: point state, map arithmetic, pixel conversion and result register.
// Depends on aig_pkg and aig_divider.
`timescale 1ns / 1ps
module aig_datapath
  import aig_pkg::*;
#(
  parameter int WARMUP_STEPS    = 100,
  parameter int PIXEL_BITS      = 12,
  parameter int COORD_FRAC_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic [1:0]            branch,
  input  logic signed [31:0]    left_edge,
  input  logic signed [31:0]    bottom_edge,
  input  logic [30:0]           view_height,
  input  logic [31:0]           x_scale,
  input  logic [31:0]           y_scale,
  input  logic [12:0]           width_px,
  input  logic [12:0]           height_px,
  input  logic [23:0]           plot_colour,
  output logic                  res_plot,
  output logic [PIXEL_BITS-1:0] res_x,
  output logic [PIXEL_BITS-1:0] res_y,
  output logic [23:0]           res_colour
);
  localparam int F = COORD_FRAC_BITS;
  localparam logic signed [63:0] ONE = 64'sd1 <<< F;
  // floor(sqrt(3) * 2^F) and the (1+r)/(2+r) quotient.
  localparam real RT = 1.7320508075688772;
  localparam logic signed [63:0] ROOT3 = 64'(longint'($floor(RT * (2.0 ** F))));
  localparam logic signed [63:0] SHIFTC =
    64'(((ONE + ROOT3) * ONE) / (2 * ONE + ROOT3));
  localparam logic signed [31:0] RST_X = 32'(((2 * ONE) + 5) / 10);
  localparam logic signed [31:0] RST_Y = 32'(((3 * ONE) + 5) / 10);
  localparam int WCW = 7;

  logic signed [31:0] px_r, py_r, a0_r, b0_r, fx_r, fy_r;
  logic signed [33:0] u_r;
  // f * r can reach about 1.73 * 2^31, so these keep one extra bit.
  logic signed [32:0] mx_r, my_r;
  logic        [31:0] den_r, acc_r;
  logic        [63:0] pmx_r, pmy_r;
  logic               pnx_r, pny_r, povx_r, povy_r;
  logic [1:0]         br_r;
  logic [WCW-1:0]     wc_r;
  logic               div_start;
  logic signed [35:0] div_num;
  logic               div_busy;
  logic signed [31:0] quo;

  aig_divider #(.FRAC(F)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(den_r), .busy(div_busy), .quo(quo)
  );
  assign stat.div_busy = div_busy;

  // One shared squarer and multiplier.
  logic signed [33:0] sq_in;
  logic        [33:0] sq_mag;
  logic        [63:0] sq_full;
  logic        [32:0] sq_out;
  always_comb begin
    case (cmd.op)
      OP_SQU:  sq_in = u_r;
      OP_D:    sq_in = 34'(py_r);
      OP_SQA:  sq_in = 34'(a0_r);
      default: sq_in = 34'(b0_r);
    endcase
    sq_mag  = sq_in[33] ? 34'(-sq_in) : 34'(sq_in);
    sq_full = 64'(sq_mag[31:0]) * 64'(sq_mag[31:0]);
    sq_out  = (sq_full >> F) > 64'h7fffffff ? 33'h7fffffff : 33'(sq_full >> F);
  end
  logic [32:0] sum_sq;
  assign sum_sq = {1'b0, acc_r} + sq_out;

  logic signed [63:0] mul_p;
  assign mul_p = 64'(cmd.op == OP_MX ? fx_r : fy_r) * ROOT3;

  // Pixel deltas.
  logic signed [33:0] dx, dy;
  logic        [33:0] mdx, mdy;
  assign dx  = 34'(px_r) - 34'(left_edge);
  assign dy  = 34'(bottom_edge) + 34'(view_height) - 34'(py_r);
  assign mdx = dx[33] ? 34'(-dx) : 34'(dx);
  assign mdy = dy[33] ? 34'(-dy) : 34'(dy);

  // Full products; anything at or above 2^64 lands off screen.
  logic [65:0] pxp, pyp;
  assign pxp = 66'(mdx) * 66'(x_scale);
  assign pyp = 66'(mdy) * 66'(y_scale);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    case (cmd.op)
      OP_DIVA: begin div_start = 1'b1; div_num = 36'(u_r) * 36'sd3; end
      OP_DIVB: begin div_start = 1'b1; div_num = 36'(py_r) * 36'sd3; end
      OP_DIVF: begin div_start = 1'b1; div_num = 36'(a0_r); end
      OP_DIVG: begin div_start = 1'b1; div_num = -36'(b0_r); end
      default: ;
    endcase
  end

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sh7fffffff) return 32'sh7fffffff;
    if (v < -36'sh80000000) return 32'sh80000000;
    return 32'(v);
  endfunction

  // Pixel check; product shifted right by F+16, so the shifted value is below 2^(48-F).
  localparam int SH = F + 16;
  function automatic logic on_axis(input logic neg, input logic over,
                                   input logic [63:0] prod, input logic [12:0] lim);
    logic [63:0] p;
    p = prod >> SH;
    if (over) return 1'b0;
    if (neg && p != 0) return 1'b0;
    return (p < 64'(lim)) && (p < (64'd1 << PIXEL_BITS));
  endfunction

  logic signed [35:0] nx, ny, tx, ty;
  always_comb begin
    nx = 36'(px_r); ny = 36'(py_r);
    tx = '0; ty = '0;
    case (br_r)
      2'd0: begin nx = 36'(a0_r); ny = 36'(b0_r); end
      2'd1: begin tx = -36'(fx_r) - 36'(my_r); ty = 36'(mx_r) - 36'(fy_r);
                  nx = 36'(sat32(tx / 2)); ny = 36'(sat32(ty / 2)); end
      2'd2: begin tx = -36'(fx_r) + 36'(my_r); ty = -36'(mx_r) - 36'(fy_r);
                  nx = 36'(sat32(tx / 2)); ny = 36'(sat32(ty / 2)); end
      default: ;
    endcase
  end

  logic plot_c;
  assign plot_c = (wc_r >= WCW'(WARMUP_STEPS)) &&
                  on_axis(pnx_r, povx_r, pmx_r, width_px) &&
                  on_axis(pny_r, povy_r, pmy_r, height_px);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= RST_X; py_r <= RST_Y; wc_r <= '0;
      res_plot <= 1'b0; res_x <= '0; res_y <= '0; res_colour <= '0;
    end else begin
      case (cmd.op)
        OP_FIN: begin
          res_plot   <= plot_c;
          res_x      <= plot_c ? PIXEL_BITS'(pmx_r >> SH) : '0;
          res_y      <= plot_c ? PIXEL_BITS'(pmy_r >> SH) : '0;
          res_colour <= plot_c ? plot_colour : '0;
          px_r <= 32'(nx); py_r <= 32'(ny);
          if (wc_r < WCW'(WARMUP_STEPS)) wc_r <= wc_r + 1'b1;
        end
        default: ;
      endcase
    end
    if (cmd.load) br_r <= branch;
    case (cmd.op)
      OP_U:   u_r <= 34'(ONE + ROOT3) - 34'(px_r);
      OP_SQU: acc_r <= 32'(sq_out);
      OP_D:   den_r <= sum_sq > 33'h7fffffff ? 32'h7fffffff : 32'(sum_sq);
      OP_A0:  a0_r <= sat32(36'(quo) - 36'(SHIFTC));
      OP_B0:  b0_r <= quo;
      OP_SQA: acc_r <= 32'(sq_out);
      OP_E:   den_r <= sum_sq > 33'h7fffffff ? 32'h7fffffff : 32'(sum_sq);
      OP_FX:  fx_r <= quo;
      OP_FY:  fy_r <= quo;
      OP_MX:  mx_r <= 33'(mul_p / ONE);
      OP_MY:  my_r <= 33'(mul_p / ONE);
      OP_PX: begin
        pmx_r <= pxp[63:0];
        povx_r <= (pxp[65:64] != 2'b00);
        pnx_r <= dx[33];
      end
      OP_PY: begin
        pmy_r <= pyp[63:0];
        povy_r <= (pyp[65:64] != 2'b00);
        pny_r <= dy[33];
      end
      default: ;
    endcase
  end
endmodule

FILE: src/aig_ctrl.sv
// Controller: sequences the datapath operations for one step.
// Depends on aig_pkg.
`timescale 1ns / 1ps
module aig_ctrl
  import aig_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  output logic     in_ready,
  input  logic     out_busy,
  output logic     out_load,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_WAIT = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd.op    = OP_NONE;
    cmd.load  = in_fire;
    out_load  = 1'b0;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: if (in_fire) begin state_nxt = S_RUN; op_nxt = OP_U; end
      S_RUN: begin
        cmd.op = op_r;
        if (op_r == OP_DIVA || op_r == OP_DIVB || op_r == OP_DIVF ||
            op_r == OP_DIVG) begin
          state_nxt = S_WAIT;
          op_nxt = op_t'(op_r + 1'b1);
        end else if (op_r == OP_PY) begin
          state_nxt = S_OUT;
        end else op_nxt = op_t'(op_r + 1'b1);
      end
      S_WAIT: if (!stat.div_busy) state_nxt = S_RUN;
      S_OUT: if (!out_busy) begin
        cmd.op = OP_FIN; out_load = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin state_r <= S_IDLE; op_r <= OP_NONE; end
    else begin state_r <= state_nxt; op_r <= op_nxt; end
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_fire_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> state_r == S_IDLE) else $error("accept outside idle");
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> state_r == S_IDLE) else $error("finish not back to idle");
`endif
endmodule

FILE: src/apollonian_ifs_point_step.sv
// Apollonian gasket chaos game point stepper, top level.
// Each input beat runs four 60-bit restoring divisions on a shared divider
// (one quotient bit per cycle) plus 14 control steps before its result is valid.
// A new beat is taken only once the last result is loaded; a zero denominator skips its divide.
// Reset (rst_n low, synchronous) restores registers and the point, clears warm-up.
// Depends on aig_pkg, aig_ctrl, aig_datapath and aig_divider.
`timescale 1ns / 1ps
module apollonian_ifs_point_step
  import aig_pkg::*;
#(
  parameter int WARMUP_STEPS    = 100,
  parameter int PIXEL_BITS      = 12,
  parameter int COORD_FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [1:0] branch
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] plot, [PB:1] pixel_x, [2PB:PB+1] pixel_y, then 24-bit colour
  output logic [(2*PIXEL_BITS+25+7)/8*8-1:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int OW = (2*PIXEL_BITS+25+7)/8*8;

  // Configuration registers; writes are always accepted.
  logic signed [31:0] left_r, bottom_r;
  logic [30:0] viewh_r;
  logic [31:0] xs_r, ys_r;
  logic [12:0] w_r, h_r;
  logic [23:0] col_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0; bottom_r <= '0; viewh_r <= 31'd33554432;
      xs_r <= 32'd25165824; ys_r <= 32'd25100288;
      w_r <= 13'd1024; h_r <= 13'd768; col_r <= 24'd1;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LEFT:   left_r   <= cfg_data;
        CFG_BOTTOM: bottom_r <= cfg_data;
        CFG_VIEWH:  viewh_r  <= cfg_data[30:0];
        CFG_XSCALE: xs_r     <= cfg_data;
        CFG_YSCALE: ys_r     <= cfg_data;
        CFG_WIDTH:  w_r      <= cfg_data[12:0];
        CFG_HEIGHT: h_r      <= cfg_data[12:0];
        CFG_COLOUR: col_r    <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic in_fire, out_load, ov_r;
  logic res_plot;
  logic [PIXEL_BITS-1:0] res_x, res_y;
  logic [23:0] res_col;
  assign in_fire = in_tvalid && in_tready;

  aig_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_ready(in_tready),
    .out_busy(ov_r && !out_tready), .out_load(out_load), .stat(stat), .cmd(cmd)
  );

  aig_datapath #(
    .WARMUP_STEPS(WARMUP_STEPS), .PIXEL_BITS(PIXEL_BITS),
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .branch(in_tdata[1:0]),
    .left_edge(left_r), .bottom_edge(bottom_r), .view_height(viewh_r),
    .x_scale(xs_r), .y_scale(ys_r), .width_px(w_r), .height_px(h_r),
    .plot_colour(col_r), .res_plot(res_plot), .res_x(res_x), .res_y(res_y),
    .res_colour(res_col)
  );

  // The datapath result register is the output beat; valid follows its load.
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (out_load) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end
  assign out_tvalid = ov_r;
  assign out_tdata = OW'({res_col, res_y, res_x, res_plot});
endmodule

FILE: tb/sv/tb.sv
// Self-checking bench for the Apollonian gasket point stepper.
// Drives branch beats, predicts every pixel result and checks it. Needs only aig_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
  import aig_pkg::*;

  localparam int      FRAC       = 24;
  localparam int      WARMUP     = 100;
  localparam int      PIX_LIMIT  = 4096;
  localparam longint  ONE_Q      = 64'sd1 <<< FRAC;
  localparam longint  PIX_FAR    = 64'sd1 <<< 40;
  localparam longint  INT32_MAX  = 64'sd2147483647;
  localparam longint  INT32_MIN  = -64'sd2147483648;
  localparam int      CYCLE_LIMIT = 4_000_000;

  typedef struct {
    bit        plot;
    bit [11:0] px;
    bit [11:0] py;
    bit [23:0] colour;
  } pixel_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;     // [1:0] branch
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;    // [0] plot, [12:1] pixel_x, [24:13] pixel_y, [48:25] colour
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  apollonian_ifs_point_step u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the view registers and of the walking point.
  longint          left_q, bottom_q, view_h;
  longint unsigned x_scale_q, y_scale_q, width_q, height_q;
  bit [23:0]       colour_q;
  longint          pt_x, pt_y;
  int              warm_steps;
  longint          root3, shift_const;

  bit [1:0]        branch_q[$];
  pixel_result_t   expected_pixels[$];
  int              beats_in, beats_issued, beats_out, plotted, errors, cycles;
  bit              quiet_in, quiet_out;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint sat32(longint v);
    if (v > INT32_MAX) return INT32_MAX;
    if (v < INT32_MIN) return INT32_MIN;
    return v;
  endfunction

  // Fixed-point quotient (num << FRAC) / den, saturating, with the
  // divide-by-zero convention of the hardware divider.
  function automatic longint qdiv(longint num, longint unsigned den);
    longint unsigned q;
    if (den == 0) return num > 0 ? INT32_MAX : (num < 0 ? INT32_MIN : 64'sd0);
    q = (mag(num) << FRAC) / den;
    if (num < 0) return q > 64'h8000_0000 ? INT32_MIN : -longint'(q);
    return q > 64'h7FFF_FFFF ? INT32_MAX : longint'(q);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) / ONE_Q;
  endfunction

  function automatic longint unsigned qsq(longint v);
    longint unsigned m;
    m = mag(v);
    return (m * m) >> FRAC;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // World offset times a Q16.16 scale gives pixels; overflow lands off screen.
  function automatic longint to_pixel(longint delta, longint unsigned scale);
    longint unsigned m, p;
    m = mag(delta);
    if (m != 0 && scale != 0 && m > 64'hFFFF_FFFF_FFFF_FFFF / scale)
      return delta < 0 ? -64'sd1 : PIX_FAR;
    p = (m * scale) >> (FRAC + 16);
    if (p > longint'(PIX_FAR)) p = PIX_FAR;
    return delta < 0 ? -longint'(p) : longint'(p);
  endfunction

  function automatic void reset_shadow();
    left_q = 0;
    bottom_q = 0;
    view_h = 33554432;
    x_scale_q = 25165824;
    y_scale_q = 25100288;
    width_q = 1024;
    height_q = 768;
    colour_q = 1;
    pt_x = (2 * ONE_Q + 5) / 10;
    pt_y = (3 * ONE_Q + 5) / 10;
    warm_steps = 0;
    root3 = int_sqrt(64'd3 << (2 * FRAC));
    shift_const = qdiv(ONE_Q + root3, 2 * ONE_Q + root3);
  endfunction

  // One chaos-game step: report the current point, then move it.
  function automatic pixel_result_t step_gasket_point(bit [1:0] branch);
    pixel_result_t r;
    longint u, a0, b0, f1x, f1y, nx, ny, px, py;
    longint unsigned d, e;
    u = ONE_Q + root3 - pt_x;
    d = qsq(u) + qsq(pt_y);
    if (d > 64'h7FFF_FFFF) d = 64'h7FFF_FFFF;
    a0 = sat32(qdiv(3 * u, d) - shift_const);
    b0 = qdiv(3 * pt_y, d);
    e = qsq(a0) + qsq(b0);
    if (e > 64'h7FFF_FFFF) e = 64'h7FFF_FFFF;
    f1x = qdiv(a0, e);
    f1y = qdiv(-b0, e);
    case (branch)
      2'd0: begin
        nx = a0;
        ny = b0;
      end
      2'd1: begin
        nx = sat32((-f1x - qmul(f1y, root3)) / 2);
        ny = sat32((qmul(f1x, root3) - f1y) / 2);
      end
      2'd2: begin
        nx = sat32((-f1x + qmul(f1y, root3)) / 2);
        ny = sat32((-qmul(f1x, root3) - f1y) / 2);
      end
      default: begin
        nx = pt_x;
        ny = pt_y;
      end
    endcase
    px = to_pixel(pt_x - left_q, x_scale_q);
    py = to_pixel(bottom_q + view_h - pt_y, y_scale_q);
    r.plot = warm_steps >= WARMUP && px >= 0 && px < longint'(width_q) && px < PIX_LIMIT
             && py >= 0 && py < longint'(height_q) && py < PIX_LIMIT;
    r.px = r.plot ? px[11:0] : 12'd0;
    r.py = r.plot ? py[11:0] : 12'd0;
    r.colour = r.plot ? colour_q : 24'd0;
    pt_x = nx;
    pt_y = ny;
    if (warm_steps < WARMUP) warm_steps++;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The run has a hard ceiling so that a hung handshake cannot stall forever.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("apollonian_ifs_point_step verification failed");
      $finish;
    end
  end

  // Input monitor: each accepted beat runs the predictor once.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      expected_pixels.push_back(step_gasket_point(in_tdata[1:0]));
      beats_in++;
    end
  end

  // Input driver. A beat on the bus stays until the monitor has counted it;
  // only then is the next one (or an idle cycle) chosen.
  always @(negedge clk) begin
    bit [1:0] nxt;
    if (rst_n && (!in_tvalid || beats_in == beats_issued)) begin
      if (branch_q.size() > 0 && (quiet_in || $urandom_range(99) >= 35)) begin
        nxt = branch_q.pop_front();
        in_tdata <= {6'd0, nxt};
        in_tvalid <= 1'b1;
        beats_issued++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side. Once, early on, the receiver refuses for a long stretch
  // while the sender keeps offering, so the block backs up onto its input.
  int  hold_left;
  bit  hold_done;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && beats_out == 150) begin
      hold_done = 1'b1;
      hold_left = 3000;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet_out || $urandom_range(99) >= 35;
    end
  end

  always @(posedge clk) begin
    pixel_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      beats_out++;
      if (expected_pixels.size() == 0) begin
        $error("result beat with no step outstanding: %h", out_tdata);
        errors++;
      end else begin
        exp_r = expected_pixels.pop_front();
        if (exp_r.plot) plotted++;
        if (out_tdata[0] !== exp_r.plot) begin
          $error("plot: expected %0d, got %0d", exp_r.plot, out_tdata[0]);
          errors++;
        end
        if (out_tdata[12:1] !== exp_r.px) begin
          $error("pixel_x: expected %0d, got %0d", exp_r.px, out_tdata[12:1]);
          errors++;
        end
        if (out_tdata[24:13] !== exp_r.py) begin
          $error("pixel_y: expected %0d, got %0d", exp_r.py, out_tdata[24:13]);
          errors++;
        end
        if (out_tdata[48:25] !== exp_r.colour) begin
          $error("colour: expected %h, got %h", exp_r.colour, out_tdata[48:25]);
          errors++;
        end
      end
    end
  end

  // Register write; only issued while the block has nothing in flight.
  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      CFG_LEFT:   left_q = longint'($signed(value));
      CFG_BOTTOM: bottom_q = longint'($signed(value));
      CFG_VIEWH:  view_h = longint'({33'd0, value[30:0]});
      CFG_XSCALE: x_scale_q = value;
      CFG_YSCALE: y_scale_q = value;
      CFG_WIDTH:  width_q = value[12:0];
      CFG_HEIGHT: height_q = value[12:0];
      default:    colour_q = value[23:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_view(logic [31:0] l, logic [31:0] b, logic [31:0] vh,
                            logic [31:0] xs, logic [31:0] ys, logic [31:0] w,
                            logic [31:0] h, logic [31:0] c);
    write_reg(CFG_LEFT, l);
    write_reg(CFG_BOTTOM, b);
    write_reg(CFG_VIEWH, vh);
    write_reg(CFG_XSCALE, xs);
    write_reg(CFG_YSCALE, ys);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_COLOUR, c);
  endtask

  // Queue random steps, mostly real maps with the odd hold-still branch,
  // and wait until every result has come back.
  task automatic run_steps(int n);
    for (int i = 0; i < n; i++)
      branch_q.push_back($urandom_range(99) < 8 ? 2'd3 : 2'($urandom_range(2)));
    forever begin
      @(posedge clk);
      if (branch_q.size() == 0 && beats_in == beats_issued && expected_pixels.size() == 0)
        break;
    end
    repeat (20) @(posedge clk);
  endtask

  initial begin
    bit [1:0] directed[] = '{0, 1, 2, 3, 3, 0, 0, 1, 1, 2, 2, 3, 0, 2, 1, 0,
                             3, 2, 2, 1, 0, 1, 2, 3, 0};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    reset_shadow();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening: every branch, including the one that leaves the
    // point in place, all inside the warm-up window.
    foreach (directed[i]) branch_q.push_back(directed[i]);
    run_steps(0);

    // Reset view, with no idling on either side for a while.
    quiet_in = 1'b1;
    quiet_out = 1'b1;
    run_steps(120);
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    run_steps(180);

    write_view(-32'sd16777216, -32'sd8388608, 32'd50331648, 32'd13107200, 32'd9830400,
               32'd640, 32'd480, $urandom);
    run_steps(250);

    // Far extremes: huge scales overflow the pixel product.
    write_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'd4096, 32'd4096, 32'hFF_FFFF);
    run_steps(200);

    // Near extremes: zero scale puts everything at the corner of a 1x1 screen.
    write_view(32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'd0);
    run_steps(200);

    // Fine zoom so that positions cross the 4096-pixel limit.
    write_view(-32'sd8388608, -32'sd8388608, 32'd16777216, 32'd268435456, 32'd268435456,
               32'd4096, 32'd4096, $urandom);
    run_steps(200);

    for (int p = 0; p < 3; p++) begin
      write_view(-$urandom_range(1 << 24), -$urandom_range(1 << 24),
                 $urandom_range(1 << 23, 3 << 24), $urandom_range(1 << 20, 1 << 26),
                 $urandom_range(1 << 20, 1 << 26), $urandom_range(1, 4096),
                 $urandom_range(1, 4096), $urandom);
      run_steps(250);
    end

    repeat (300) @(posedge clk);
    $display("Ran %0d steps over eight view settings; %0d results, %0d of them plotted.",
             beats_in, beats_out, plotted);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("apollonian_ifs_point_step verification clean");
    end else begin
      $display("apollonian_ifs_point_step verification failed");
    end
    $finish;
  end

endmodule
